[rtl/core/u2d_pkg.sv]
// ----------------------------------------------------------------------------
// u2d_pkg
// Shared widths, constants and controller/datapath interface types for the
// 128-bit binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2d_pkg;

  localparam int VALUE_W        = 128;
  localparam int HALF_W         = 64;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 6;
  localparam int MAX_DIGITS_DEF = 39;
  localparam int BIT_CNT_W      = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture a new value, clear the digit register
    logic dabble;      // one adjust-and-shift step
    logic digit_shift; // move the next lower digit to the top slot
    logic out_load;    // put the top digit into the output register
    logic out_last;    // marker that goes with out_load
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic top_zero;    // top digit slot holds zero
    logic ovf;         // value did not fit in the digit register
  } stat_t;

endpackage

`default_nettype wire

[rtl/core/u2d_dpath.sv]
// ----------------------------------------------------------------------------
// u2d_dpath
// Double dabble datapath: binary shift register, BCD digit register with
// per-digit add-3 adjust, overflow flag and the output payload register.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_dpath #(
  parameter int MAX_DIGITS = u2d_pkg::MAX_DIGITS_DEF
) (
  input  wire                               clk,
  input  wire  [u2d_pkg::HALF_W-1:0]        value_high,
  input  wire  [u2d_pkg::HALF_W-1:0]        value_low,
  input  u2d_pkg::cmd_t                     cmd,
  output u2d_pkg::stat_t                    stat,
  output logic [u2d_pkg::CHAR_W-1:0]        digit_char,
  output logic                              is_last
);

  localparam int BCD_W = MAX_DIGITS * u2d_pkg::DIGIT_W;

  logic [u2d_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]            bcd_r, bcd_nxt, bcd_adj;
  logic                        ovf_r, ovf_nxt;
  logic [u2d_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                        last_r, last_nxt;
  logic [u2d_pkg::DIGIT_W-1:0] top_digit;

  // add 3 to every digit that is 5 or more, so the doubling carries in decimal
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_adj
    logic [u2d_pkg::DIGIT_W-1:0] d;
    assign d = bcd_r[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W];
    assign bcd_adj[i*u2d_pkg::DIGIT_W +: u2d_pkg::DIGIT_W] =
      (d >= 4'd5) ? d + 4'd3 : d;
  end

  assign top_digit = bcd_r[BCD_W-1 -: u2d_pkg::DIGIT_W];

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    ovf_nxt  = ovf_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (cmd.load) begin
      bin_nxt = {value_high, value_low};
      bcd_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (cmd.dabble) begin
      bin_nxt = bin_r << 1;
      bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[u2d_pkg::VALUE_W-1]};
      // a bit carried out of the top digit means the value has more digits
      ovf_nxt = ovf_r | bcd_adj[BCD_W-1];
    end else if (cmd.digit_shift) begin
      bcd_nxt = bcd_r << u2d_pkg::DIGIT_W;
    end
    if (cmd.out_load) begin
      char_nxt = u2d_pkg::ASCII_ZERO + {2'b00, top_digit};
      last_nxt = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    ovf_r  <= ovf_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign stat.top_zero = (top_digit == '0);
  assign stat.ovf      = ovf_r;
  assign digit_char    = char_r;
  assign is_last       = last_r;

endmodule

`default_nettype wire

[rtl/core/u2d_ctrl.sv]
// ----------------------------------------------------------------------------
// u2d_ctrl
// Sequencer: accepts a value, runs 128 dabble steps, then walks the digits
// from the top, dropping leading zeros and feeding the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_ctrl #(
  parameter int MAX_DIGITS = u2d_pkg::MAX_DIGITS_DEF
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire             out_ready,
  input  u2d_pkg::stat_t  stat,
  output u2d_pkg::cmd_t   cmd
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [u2d_pkg::BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]                dig_cnt_r, dig_cnt_nxt;
  logic                            lead_r, lead_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            out_free;
  logic                            cnt_one;

  assign out_free = !out_valid_r || out_ready;
  assign cnt_one  = (dig_cnt_r == CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    lead_nxt      = lead_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = '0;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        cmd.dabble  = 1'b1;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (&bit_cnt_r) begin
          dig_cnt_nxt = CNT_W'(MAX_DIGITS);
          lead_nxt    = 1'b1;
          state_nxt   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (lead_r && !stat.ovf && stat.top_zero && !cnt_one) begin
          // drop a leading zero
          cmd.digit_shift = 1'b1;
          dig_cnt_nxt     = dig_cnt_r - 1'b1;
        end else if (out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_last    = cnt_one;
          cmd.digit_shift = 1'b1;
          out_valid_nxt   = 1'b1;
          lead_nxt        = 1'b0;
          dig_cnt_nxt     = dig_cnt_r - 1'b1;
          if (cnt_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
      lead_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      lead_r      <= lead_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[rtl/core/u128_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// u128_to_decimal_ascii
// Unsigned 128-bit binary to decimal ASCII digit stream (double dabble).
// ----------------------------------------------------------------------------
// Input channel: in_value_high/in_value_low form one 128-bit value; a
// transaction completes when in_valid and in_ready are both high.
// Output channel: one transaction per decimal digit, most significant first,
// leading zeros dropped; out_is_last marks the final digit. Zero gives "0".
// Sequence: the accept, then one dabble step per input bit (one bit per cycle
// through the BCD adjust logic), then one step for each of the MAX_DIGITS
// digit slots that either drops a leading zero or loads that digit into the
// output register.
// in_ready is high only while idle; a new value may be accepted while the
// last digit of the previous one still waits in the output register.
// A receiver stall holds the output register and digit loads; zero drops go on.
// Reset (rst_n low, synchronous) returns to idle and drops any pending digit.
// If the value has more than MAX_DIGITS digits, its low MAX_DIGITS digits
// are emitted, zeros included.
// ----------------------------------------------------------------------------
`default_nettype none

module u128_to_decimal_ascii #(
  parameter int MAX_DIGITS = u2d_pkg::MAX_DIGITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [u2d_pkg::HALF_W-1:0]   in_value_high,
  input  wire  [u2d_pkg::HALF_W-1:0]   in_value_low,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [u2d_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                         out_is_last
);

  u2d_pkg::cmd_t  cmd;
  u2d_pkg::stat_t stat;

  u2d_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  u2d_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk        (clk),
    .value_high (in_value_high),
    .value_low  (in_value_low),
    .cmd        (cmd),
    .stat       (stat),
    .digit_char (out_digit_char),
    .is_last    (out_is_last)
  );

endmodule

`default_nettype wire

[rtl/core/u2d_chk.sv]
// ----------------------------------------------------------------------------
// u2d_chk
// Port-level checker for u128_to_decimal_ascii, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module u2d_chk (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_valid,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [u2d_pkg::CHAR_W-1:0]    out_digit_char,
  input wire                          out_is_last
);

  // hold a stalled digit
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char)
      && $stable(out_is_last))
    else $error("stalled output transaction changed");

  a_out_digit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_digit_char >= 6'h30 && out_digit_char <= 6'h39)
    else $error("output character is not a decimal digit");

  // no new value until the conversion has finished
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during conversion");

  // a pending non-final digit means the current number is still being emitted
  a_no_accept_mid_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_last |-> !in_ready)
    else $error("input ready while digits remain");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear output");

endmodule

bind u128_to_decimal_ascii u2d_chk u_chk (.*);

`default_nettype wire

[verif/tb_u128_to_decimal_ascii.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_u128_to_decimal_ascii
// Self-checking bench for the 128-bit binary to decimal ASCII converter.
// Each accepted value is divided down by ten into its decimal digits and
// the expected character stream (MSD first, last marker on the final digit)
// is queued. Every digit transaction on the output channel is checked
// against the queue. Directed corner values run first, then random values
// over four traffic phases with differing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

class digit_scoreboard;
  typedef struct packed {
    logic [u2d_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_t;

  int          max_digits;
  digit_t      expected_q[$];
  int unsigned err_cnt;
  int unsigned values_seen;
  int unsigned digits_seen;

  function new(int digits);
    max_digits  = digits;
    err_cnt     = 0;
    values_seen = 0;
    digits_seen = 0;
  endfunction

  task report(string msg);
    err_cnt++;
    if (err_cnt <= 40) begin
      $display("[%0t] MISMATCH: %0s", $time, msg);
    end
  endtask

  // Split the value into decimal digits, least significant first, then
  // queue them most significant first with the marker on the final one.
  function void note_value(bit [63:0] hi, bit [63:0] lo);
    bit [127:0] rest;
    bit [3:0]   lsd_first[$];
    int         n;
    int         k;
    digit_t     d;
    rest = {hi, lo};
    n    = 0;
    do begin
      lsd_first.push_back(4'(rest % 10));
      rest = rest / 10;
      n++;
    end while (rest != 0 && n < max_digits);
    for (k = n - 1; k >= 0; k--) begin
      d.ch   = u2d_pkg::ASCII_ZERO + u2d_pkg::CHAR_W'(lsd_first[k]);
      d.last = (k == 0);
      expected_q.push_back(d);
    end
    values_seen++;
  endfunction

  task check_digit(logic [u2d_pkg::CHAR_W-1:0] ch, logic last);
    digit_t d;
    digits_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("digit 0x%02h (last=%0b) with nothing pending", ch, last));
    end else begin
      d = expected_q.pop_front();
      if (ch !== d.ch) begin
        report($sformatf("digit_char 0x%02h, want 0x%02h", ch, d.ch));
      end
      if (last !== d.last) begin
        report($sformatf("is_last %0b, want %0b (char 0x%02h)", last, d.last, d.ch));
      end
    end
  endtask

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_u128_to_decimal_ascii;

  localparam int          RANDOM_PER_PHASE = 115;
  localparam int unsigned CYCLE_LIMIT      = 1000000;
  localparam int          DRAIN_LIMIT      = 50000;

  logic                         clk           = 1'b0;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic [u2d_pkg::HALF_W-1:0]   in_value_high = '0;
  logic [u2d_pkg::HALF_W-1:0]   in_value_low  = '0;
  logic                         out_ready     = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [u2d_pkg::CHAR_W-1:0]   out_digit_char;
  logic                         out_is_last;

  int unsigned     cycle_cnt      = 0;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  digit_scoreboard sb;

  u128_to_decimal_ascii uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value_high  (in_value_high),
    .in_value_low   (in_value_low),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_is_last    (out_is_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits still pending", cycle_cnt,
               sb.pending());
      $display("u128_to_decimal_ascii verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_digit(out_digit_char, out_is_last);
    end
  end

  function automatic bit [127:0] pow10(int e);
    bit [127:0] p;
    p = 1;
    repeat (e) p = p * 10;
    return p;
  endfunction

  function automatic bit [127:0] random_value();
    bit [127:0] v;
    int         nbits;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        // spread the digit count by trimming to a random width
        nbits = $urandom_range(128);
        if (nbits < 128) v = v & ((128'd1 << nbits) - 1);
      end
      5, 6: ;
      7: v = pow10($urandom_range(38)) + $urandom_range(2) - 1;
      8: v = $urandom_range(1000);
      default: v = $urandom_range(1, 9) * pow10($urandom_range(38));
    endcase
    return v;
  endfunction

  // Present one value and hold it until the block takes it.
  task automatic send_value(bit [127:0] v);
    int gap;
    gap = 0;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = ($urandom_range(7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 6);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_value_high <= v[127:64];
    in_value_low  <= v[63:0];
    do @(posedge clk); while (!in_ready);
    sb.note_value(v[127:64], v[63:0]);
  endtask

  initial begin
    bit [127:0] directed_q[$];
    int         i;
    int         ph;
    int         drain_cnt;

    sb = new(u2d_pkg::MAX_DIGITS_DEF);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners: zero, digit boundaries, half boundaries, widest values,
    // values full of inner zeros, alternating bit patterns
    directed_q = '{128'd0, 128'd1, 128'd9, 128'd10, 128'd99, 128'd100,
                   128'd1000000, {64'd0, {64{1'b1}}}, {64'd1, 64'd0},
                   {{64{1'b1}}, 64'd0}, {128{1'b1}}, {1'b1, 127'd0},
                   {128{1'b1}} - 1, {64{2'b10}}, {64{2'b01}}};
    directed_q.push_back(pow10(19));
    directed_q.push_back(pow10(19) - 1);
    directed_q.push_back(pow10(38));
    directed_q.push_back(pow10(38) - 1);
    directed_q.push_back(pow10(38) * 3 + 7);
    directed_q.push_back(128'd0);
    foreach (directed_q[j]) send_value(directed_q[j]);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      for (i = 0; i < RANDOM_PER_PHASE; i++) send_value(random_value());
    end
    in_valid <= 1'b0;

    drain_cnt = 0;
    while (sb.pending() > 0 && drain_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cnt++;
    end
    repeat (200) @(posedge clk);
    if (sb.pending() > 0) begin
      sb.report($sformatf("%0d expected digits never arrived", sb.pending()));
    end

    $display("converted %0d values (directed corners plus random widths and powers of ten)",
             sb.values_seen);
    $display("checked %0d digit transactions across four stall/gap phases, %0d errors",
             sb.digits_seen, sb.err_cnt);
    if (sb.err_cnt == 0) begin
      $display("u128_to_decimal_ascii verification clean");
    end else begin
      $display("u128_to_decimal_ascii verification failed");
    end
    $finish;
  end

endmodule
